@@ hw/rtl/infix_to_postfix_converter_assert.svh @@
// Assertion macros for the infix-to-postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define ITP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("infix_to_postfix_converter: same-cycle check failed");
`define ITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("infix_to_postfix_converter: next-cycle check failed");
`else
`define ITP_ASSERT_IMP(label, ante, cons)
`define ITP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/itp_pkg.sv @@
// Shared types, character codes and decode functions for the converter.
`timescale 1ns / 1ps
package itp_pkg;

    // Character codes
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_UPPER_LO = 8'h41;
    localparam logic [7:0] CH_UPPER_HI = 8'h5A;
    localparam logic [7:0] CH_LOWER_LO = 8'h61;
    localparam logic [7:0] CH_LOWER_HI = 8'h7A;
    localparam logic [7:0] CH_NUL      = 8'h00;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNMATCHED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    // Precedence levels
    localparam logic [1:0] PREC_OTHER = 2'd0;
    localparam logic [1:0] PREC_ADD   = 2'd1;
    localparam logic [1:0] PREC_MUL   = 2'd2;

    typedef enum logic [1:0] {
        CLS_PASS,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP
    } itp_cls_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EVAL,
        ST_FINISH
    } itp_state_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       end_marker;
        logic [1:0] error_code;
    } itp_res_t;

    typedef struct packed {
        logic     push;
        logic     finish;
        itp_res_t res;
    } itp_emit_req_t;

    typedef struct packed {
        logic ack;
        logic pend_valid;
    } itp_emit_rsp_t;

    function automatic itp_cls_t char_class(input logic [7:0] c);
        itp_cls_t cls;
        if (c inside {[CH_DIGIT_LO:CH_DIGIT_HI], [CH_UPPER_LO:CH_UPPER_HI],
                      [CH_LOWER_LO:CH_LOWER_HI]})
            cls = CLS_PASS;
        else if (c == CH_LPAREN)
            cls = CLS_OPEN;
        else if (c == CH_RPAREN)
            cls = CLS_CLOSE;
        else
            cls = CLS_OP;
        return cls;
    endfunction

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        if (c inside {CH_PLUS, CH_MINUS})
            p = PREC_ADD;
        else if (c inside {CH_STAR, CH_SLASH})
            p = PREC_MUL;
        else
            p = PREC_OTHER;
        return p;
    endfunction

endpackage

@@ hw/rtl/itp_in_if.sv @@
// Input channel: one expression character or end flag per beat.
`timescale 1ns / 1ps
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_expr;

    modport source (output valid, output char_in, output end_of_expr, input ready);
    modport sink   (input valid, input char_in, input end_of_expr, output ready);
endinterface

@@ hw/rtl/itp_out_if.sv @@
// Output channel: one postfix character or marker per beat.
`timescale 1ns / 1ps
interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       end_marker;
    logic       last;
    logic [1:0] error_code;

    modport source (output valid, output char_out, output end_marker, output last,
                    output error_code, input ready);
    modport sink   (input valid, input char_out, input end_marker, input last,
                    input error_code, output ready);
endinterface

@@ hw/rtl/itp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/itp_emit.sv @@
// Result staging: holds one pending result until its last flag is known.
`timescale 1ns / 1ps
module itp_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  itp_pkg::itp_emit_req_t req,
    output itp_pkg::itp_emit_rsp_t rsp,
    itp_out_if.source             out_ch
);
    import itp_pkg::*;

    logic     pend_valid_reg, pend_valid_next;
    itp_res_t pend_reg, pend_next;
    logic     out_valid_reg, out_valid_next;
    itp_res_t out_res_reg, out_res_next;
    logic     out_last_reg, out_last_next;
    logic     out_free;
    logic     ack;

    // A staged result may move out once the output register frees up
    assign out_free = !out_valid_reg || out_ch.ready;
    assign ack      = !pend_valid_reg || out_free;

    assign rsp.ack        = ack;
    assign rsp.pend_valid = pend_valid_reg;

    // Advance pending result to the output register on a new result or finish
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if ((req.push || req.finish) && ack)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_res_next   = pend_reg;
                out_last_next  = req.finish;
            end
            if (req.push)
            begin
                pend_valid_next = 1'b1;
                pend_next       = req.res;
            end
            else
            begin
                pend_valid_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.char_out   = out_res_reg.char_out;
    assign out_ch.end_marker = out_res_reg.end_marker;
    assign out_ch.error_code = out_res_reg.error_code;
    assign out_ch.last       = out_last_reg;

endmodule

@@ hw/rtl/itp_ctrl.sv @@
// Stack sequencer: reads the top entry, decides pop, drop or push, writes back.
`timescale 1ns / 1ps
module itp_ctrl #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    itp_in_if.sink                        in_ch,
    output logic                          ram_we,
    output logic [$clog2(STACK_DEPTH)-1:0] ram_waddr,
    output logic [7:0]                    ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(STACK_DEPTH)-1:0] ram_raddr,
    input  logic [7:0]                    ram_rdata,
    output itp_pkg::itp_emit_req_t        emit_req,
    input  itp_pkg::itp_emit_rsp_t        emit_rsp
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    itp_state_t      state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [7:0]      char_reg, char_next;
    logic            eoe_reg, eoe_next;

    itp_cls_t        cls;
    logic            cnt_zero;
    logic            cnt_full;
    logic [CW-1:0]   cnt_dec;
    logic [CW-1:0]   cnt_inc;
    logic            top_open;
    logic            pop_wins;
    logic            want_read;
    logic            d_push;
    logic            d_gen;
    itp_res_t        d_res;
    logic            e_pop;
    logic            e_drop;
    logic            e_gen;
    itp_res_t        e_res;

    // Decode the held character against the count and the top entry
    always_comb
    begin
        cls       = char_class(char_reg);
        cnt_zero  = (count_reg == '0);
        cnt_full  = (count_reg == CW'(STACK_DEPTH));
        cnt_dec   = count_reg - CW'(1);
        cnt_inc   = count_reg + CW'(1);
        top_open  = (ram_rdata == CH_LPAREN);
        pop_wins  = (prec_of(char_reg) <= prec_of(ram_rdata));
        want_read = !cnt_zero && (eoe_reg || cls == CLS_CLOSE || cls == CLS_OP);
        d_push    = !want_read && !eoe_reg && (cls == CLS_OPEN || cls == CLS_OP);
        d_gen     = !want_read && !(d_push && !cnt_full);
        if (eoe_reg)
            d_res = '{char_out: CH_NUL, end_marker: 1'b1, error_code: ERR_NONE};
        else if (cls == CLS_PASS)
            d_res = '{char_out: char_reg, end_marker: 1'b0, error_code: ERR_NONE};
        else if (cls == CLS_CLOSE)
            d_res = '{char_out: CH_NUL, end_marker: 1'b0, error_code: ERR_UNMATCHED};
        else
            d_res = '{char_out: CH_NUL, end_marker: 1'b0, error_code: ERR_OVERFLOW};
        e_pop  = eoe_reg || (cls == CLS_CLOSE && !top_open) || (cls == CLS_OP && pop_wins);
        e_drop = !eoe_reg && cls == CLS_CLOSE && top_open;
        e_gen  = e_pop || (!e_drop && cnt_full);
        if (e_pop)
            e_res = '{char_out: ram_rdata, end_marker: 1'b0, error_code: ERR_NONE};
        else
            e_res = '{char_out: CH_NUL, end_marker: 1'b0, error_code: ERR_OVERFLOW};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (want_read)
                    state_next = ST_EVAL;
                else if (!d_gen || emit_rsp.ack)
                    state_next = ST_FINISH;
            end
            ST_EVAL:
            begin
                if (!e_gen)
                    state_next = ST_FINISH;
                else if (emit_rsp.ack)
                    state_next = e_pop ? ST_DECIDE : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (emit_rsp.ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: memory access, result request, count update
    always_comb
    begin
        in_ch.ready = 1'b0;
        char_next   = char_reg;
        eoe_next    = eoe_reg;
        count_next  = count_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = char_reg;
        ram_re      = 1'b0;
        ram_raddr   = cnt_dec[AW-1:0];
        emit_req    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    char_next = in_ch.char_in;
                    eoe_next  = in_ch.end_of_expr;
                end
            end
            ST_DECIDE:
            begin
                if (want_read)
                begin
                    ram_re = 1'b1;
                end
                else if (d_gen)
                begin
                    emit_req.push = 1'b1;
                    emit_req.res  = d_res;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = cnt_inc;
                end
            end
            ST_EVAL:
            begin
                if (e_gen)
                begin
                    emit_req.push = 1'b1;
                    emit_req.res  = e_res;
                    if (e_pop && emit_rsp.ack)
                        count_next = cnt_dec;
                end
                else if (e_drop)
                begin
                    count_next = cnt_dec;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = cnt_inc;
                end
            end
            ST_FINISH:
            begin
                emit_req.finish = 1'b1;
            end
            default:
            begin
                emit_req = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Held input beat
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        eoe_reg  <= eoe_next;
    end

endmodule

@@ hw/rtl/infix_to_postfix_converter.sv @@
// Top level of the shunting-yard infix-to-postfix converter.
//
//   channel  | dir | beat payload                                | handshake
//   ---------+-----+---------------------------------------------+-----------
//   in_ch    | in  | char_in[7:0], end_of_expr                   | valid/ready
//   out_ch   | out | char_out[7:0], end_marker, last, error_code | valid/ready
//
// One input beat at a time: the beat is accepted in IDLE, each stack decision is made in
// DECIDE and each memory read is used in EVAL, so each popped entry passes through DECIDE
// and EVAL; FINISH then releases the final result. A plain character passes IDLE, DECIDE, FINISH.
// The stack lives in a RAM with registered read; that read sets the pace.
// Reset empties the stack count at once; stack entries are not cleared.
// A stalled output holds the sequencer, and input is taken again once it is idle.
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_assert.svh"
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input logic       clk,
    input logic       rst_n,
    itp_in_if.sink    in_ch,
    itp_out_if.source out_ch
);
    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    itp_emit_req_t emit_req;
    itp_emit_rsp_t emit_rsp;

    // Stack sequencer
    itp_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .emit_req  (emit_req),
        .emit_rsp  (emit_rsp)
    );

    // Operator stack storage
    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result staging and output register
    itp_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (emit_req),
        .rsp    (emit_rsp),
        .out_ch (out_ch)
    );

    `ITP_ASSERT_IMP(a_no_rw_overlap, ram_we, !ram_re)
    `ITP_ASSERT_IMP(a_waddr_in_range, ram_we, int'(ram_waddr) < STACK_DEPTH)
    `ITP_ASSERT_IMP(a_end_is_last, out_ch.valid && out_ch.end_marker, out_ch.last && out_ch.char_out == CH_NUL)
    `ITP_ASSERT_IMP(a_accept_drained, in_ch.valid && in_ch.ready, !emit_rsp.pend_valid)
    `ITP_ASSERT_NEXT(a_one_beat_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the shunting-yard infix-to-postfix converter.
`timescale 1ns / 1ps
module tb_top;
    import itp_pkg::*;

    localparam int STACK_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       endm;
        logic       lst;
        logic [1:0] err;
    } postfix_beat_t;

    // Operator-stack model of the converter plus the list of postfix beats still due
    class postfix_checker;
        logic [7:0]    op_stack [STACK_DEPTH];
        int unsigned   fill = 0;
        postfix_beat_t caused [$];
        postfix_beat_t postfix_due [$];
        int unsigned   errors = 0;

        function int unsigned op_rank(logic [7:0] c);
            if (c == CH_PLUS || c == CH_MINUS)
                return 1;
            if (c == CH_STAR || c == CH_SLASH)
                return 2;
            return 0;
        endfunction

        function bit is_operand(logic [7:0] c);
            return (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) ||
                   (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
                   (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
        endfunction

        function void emit(logic [7:0] ch, logic endm, logic [1:0] err);
            postfix_beat_t b;
            b.ch   = ch;
            b.endm = endm;
            b.lst  = 1'b0;
            b.err  = err;
            caused.push_back(b);
        endfunction

        function void pop_emit();
            fill--;
            emit(op_stack[fill], 1'b0, ERR_NONE);
        endfunction

        // Push, or flag an overflow and drop the push when the stack is full
        function void push_op(logic [7:0] c);
            if (fill >= STACK_DEPTH)
                emit(CH_NUL, 1'b0, ERR_OVERFLOW);
            else
            begin
                op_stack[fill] = c;
                fill++;
            end
        endfunction

        function void note_input(logic [7:0] c, logic e);
            int unsigned rank;
            caused.delete();
            if (e)
            begin
                while (fill > 0)
                    pop_emit();
                emit(CH_NUL, 1'b1, ERR_NONE);
            end
            else if (is_operand(c))
                emit(c, 1'b0, ERR_NONE);
            else if (c == CH_LPAREN)
                push_op(c);
            else if (c == CH_RPAREN)
            begin
                while (fill > 0 && op_stack[fill - 1] != CH_LPAREN)
                    pop_emit();
                if (fill > 0)
                    fill--;
                else
                    emit(CH_NUL, 1'b0, ERR_UNMATCHED);
            end
            else
            begin
                rank = op_rank(c);
                while (fill > 0 && rank <= op_rank(op_stack[fill - 1]))
                    pop_emit();
                push_op(c);
            end
            if (caused.size() > 0)
                caused[caused.size() - 1].lst = 1'b1;
            foreach (caused[i])
                postfix_due.push_back(caused[i]);
        endfunction

        function void check_result(postfix_beat_t got);
            postfix_beat_t want;
            if (postfix_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch: unexpected beat char %h end %b last %b err %0d",
                             got.ch, got.endm, got.lst, got.err);
                return;
            end
            want = postfix_due.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"mismatch: expected char %h end %b last %b err %0d, ",
                              "got char %h end %b last %b err %0d"},
                             want.ch, want.endm, want.lst, want.err,
                             got.ch, got.endm, got.lst, got.err);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle = 1'b0;
    int unsigned cycle_count = 0;
    postfix_checker sb;
    logic [8:0] expr_q [$];

    itp_in_if  in_ch ();
    itp_out_if out_ch ();

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Free-running clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Send one beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [7:0] c, input logic e);
        while (!no_idle && $urandom_range(0, 99) < 32)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.char_in     <= c;
        in_ch.end_of_expr <= e;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_input(c, e);
    endtask

    // Hold off input until every due beat is back and the block has settled
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.postfix_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_operand();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0:       c = CH_DIGIT_LO + 8'($urandom_range(0, 9));
            1:       c = CH_UPPER_LO + 8'($urandom_range(0, 25));
            default: c = CH_LOWER_LO + 8'($urandom_range(0, 25));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] random_op();
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0, 1, 2: c = CH_PLUS;
            3, 4:    c = CH_MINUS;
            5, 6, 7: c = CH_STAR;
            8:       c = CH_SLASH;
            9:       c = "^";
            10:      c = CH_NUL;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // Append an operand or a parenthesized subexpression
    function automatic void add_term(int nest);
        if (nest < 3 && $urandom_range(0, 3) == 0)
        begin
            expr_q.push_back({1'b0, CH_LPAREN});
            add_term(nest + 1);
            repeat ($urandom_range(1, 2))
            begin
                expr_q.push_back({1'b0, random_op()});
                add_term(nest + 1);
            end
            expr_q.push_back({1'b0, CH_RPAREN});
        end
        else
            expr_q.push_back({1'b0, random_operand()});
    endfunction

    // Nest close to the stack depth, at times driving it past full
    function automatic void add_deep_nest();
        repeat ($urandom_range(30, 34))
            expr_q.push_back({1'b0, CH_LPAREN});
        repeat ($urandom_range(1, 3))
            expr_q.push_back({1'b0, random_op()});
        expr_q.push_back({1'b0, random_operand()});
        repeat ($urandom_range(0, 3))
            expr_q.push_back({1'b0, CH_RPAREN});
    endfunction

    // Receiver: check each accepted beat, stall at random
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                sb.check_result('{out_ch.char_out, out_ch.end_marker, out_ch.last,
                                  out_ch.error_code});
            out_ch.ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 32);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned sent;
        int unsigned pick;
        int unsigned seq_count;
        sent      = 0;
        seq_count = 0;
        sb        = new;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.char_in     <= 8'h00;
        in_ch.end_of_expr <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operator, parens, field extremes, odd characters
        send_beat("a", 1'b0);
        send_beat(CH_PLUS, 1'b0);
        send_beat("B", 1'b0);
        send_beat(CH_STAR, 1'b0);
        send_beat(CH_LPAREN, 1'b0);
        send_beat("9", 1'b0);
        send_beat(CH_MINUS, 1'b0);
        send_beat("z", 1'b0);
        send_beat(CH_RPAREN, 1'b0);
        send_beat(CH_SLASH, 1'b0);
        send_beat("Z", 1'b0);
        send_beat(CH_NUL, 1'b1);
        // unmatched close paren on an empty stack
        send_beat(CH_RPAREN, 1'b0);
        // zero and all-ones characters act as lowest-precedence operators
        send_beat(CH_NUL, 1'b0);
        send_beat("0", 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat("A", 1'b0);
        send_beat(8'hFF, 1'b1);
        // open parens left at end are flushed; a rank-0 operator pops them
        send_beat(CH_LPAREN, 1'b0);
        send_beat(CH_LPAREN, 1'b0);
        send_beat(CH_NUL, 1'b0);
        send_beat(CH_LPAREN, 1'b0);
        send_beat(8'h5A, 1'b1);

        hold_until_drained();

        // Random: mostly well-formed expressions, some deep nesting, some noise
        while (sent < RANDOM_ITEMS)
        begin
            no_idle = (sent >= 40 && sent < 80);
            pick = $urandom_range(0, 99);
            expr_q.delete();
            if (seq_count == 0 || (pick >= 60 && pick < 75))
            begin
                add_deep_nest();
                expr_q.push_back({1'b1, 8'($urandom_range(0, 255))});
            end
            else if (pick < 60)
            begin
                add_term(0);
                while ($urandom_range(0, 3) != 0 && expr_q.size() < 14)
                begin
                    expr_q.push_back({1'b0, random_op()});
                    add_term(0);
                end
                expr_q.push_back({1'b1, 8'($urandom_range(0, 255))});
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    expr_q.push_back({1'($urandom_range(0, 5) == 0),
                                      8'($urandom_range(0, 255))});
            end
            foreach (expr_q[i])
                send_beat(expr_q[i][7:0], expr_q[i][8]);
            sent += expr_q.size();
            seq_count++;
        end
        no_idle = 1'b0;
        in_ch.valid <= 1'b0;

        // Drain
        while (sb.postfix_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.postfix_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
